/* rtl/pvh_pkg.sv */
`default_nettype none

package pvh_pkg;

   localparam int BLK_W     = 128;
   localparam int HALF_W    = 64;
   localparam int BLK_BYTES = 16;
   localparam int CNT_W     = 5;
   localparam int TOTAL_W   = 32;
   localparam int Q_DEPTH   = 2;
   localparam int Q_AW      = 1;
   localparam int Q_CW      = 2;

   localparam logic [1:0] CMD_AAD = 2'd0;
   localparam logic [1:0] CMD_MSG = 2'd1;
   localparam logic [1:0] CMD_FIN = 2'd2;

   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   // x^128 mod P = x^127 + x^126 + x^121 + 1
   localparam logic [BLK_W-1:0] POLY_LOW = {64'hC200_0000_0000_0000, 64'h0000_0000_0000_0001};
   // x^-128 mod P
   localparam logic [BLK_W-1:0] X_INV    = {64'h9204_0000_0000_0000, 64'h0000_0000_0000_0001};

   typedef struct packed {
      logic [1:0]        cmd;
      logic [HALF_W-1:0] block_low;
      logic [HALF_W-1:0] block_high;
      logic [CNT_W-1:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [HALF_W-1:0] tag_low;
      logic [HALF_W-1:0] tag_high;
   } rsp_type;

   // classified work item between front and back
   typedef struct packed {
      logic [1:0]       cmd;
      logic [BLK_W-1:0] data;
      logic [CNT_W-1:0] count;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } q_head_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef logic [BLK_W-1:0] red_tbl_type [0:BLK_W-2];

   // residues of x^128 .. x^254 mod P
   function automatic red_tbl_type red_table_init();
      red_tbl_type      t;
      logic [BLK_W-1:0] v;
      v = POLY_LOW;
      for (int k = 0; k < BLK_W - 1; k++) begin
         t[k] = v;
         v = {v[BLK_W-2:0], 1'b0} ^ (v[BLK_W-1] ? POLY_LOW : '0);
      end
      return t;
   endfunction

   localparam red_tbl_type RED_TABLE = red_table_init();

   // full-width carry-less multiply, then fold the upper half through the residue table
   function automatic logic [BLK_W-1:0] gf_mul(input logic [BLK_W-1:0] a,
                                               input logic [BLK_W-1:0] b);
      logic [2*BLK_W-2:0] prod;
      logic [BLK_W-1:0]   res;
      prod = '0;
      for (int i = 0; i < BLK_W; i++) begin
         if (a[i]) prod = prod ^ ({{(BLK_W-1){1'b0}}, b} << i);
      end
      res = prod[BLK_W-1:0];
      for (int k = 0; k < BLK_W - 1; k++) begin
         if (prod[BLK_W+k]) res = res ^ RED_TABLE[k];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/polyval_universal_hash.sv */
// Channel   Dir  Handshake             Beat
// req_      in   req_valid/req_stall   cmd, block_low, block_high, byte_count
// rsp_      out  rsp_valid/rsp_stall   tag_low, tag_high
// csr_      in   csr_we                csr_index selects key low/high, csr_wdata
//
// One block per cycle while the scaled key is ready: each absorb runs through a single full-width
// carry-less multiply with reduction, the product written straight back to the accumulator.
// A finish posts its tag in the cycle after it leaves the two-beat queue.
// After reset and after each key write the multiplier is borrowed for
// forming the scaled key; queued beats wait for it.
// Synchronous active-high reset clears key, accumulator, totals and queue.
// rsp_stall holds only a finish; absorbs keep flowing behind a waiting tag.
`default_nettype none

module polyval_universal_hash (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire pvh_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output pvh_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [pvh_pkg::HALF_W-1:0] csr_wdata
);
   import pvh_pkg::*;

   logic         push_valid;
   op_type       push_op;
   logic         pop;
   q_head_type   head;
   q_status_type q_status;

   pvh_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   pvh_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   pvh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = q_status.full;

endmodule

`default_nettype wire

/* rtl/pvh_front.sv */
`default_nettype none

module pvh_front (
   input  wire logic            req_valid,
   input  wire pvh_pkg::req_type req_data,
   output logic                 push_valid,
   output pvh_pkg::op_type      push_op
);
   import pvh_pkg::*;

   logic [CNT_W-1:0] n_clamp;
   logic [BLK_W-1:0] mask;

   always_comb begin
      n_clamp = (req_data.byte_count > CNT_W'(BLK_BYTES)) ? CNT_W'(BLK_BYTES)
                                                            : req_data.byte_count;
      for (int j = 0; j < BLK_BYTES; j++) begin
         mask[j*8 +: 8] = (CNT_W'(j) < n_clamp) ? 8'hFF : 8'h00;
      end

      push_op.cmd   = req_data.cmd;
      push_op.data  = {req_data.block_high, req_data.block_low} & mask;
      push_op.count = n_clamp;
      push_valid    = 1'b0;

      unique case (req_data.cmd)
         CMD_AAD, CMD_MSG: begin
            // empty blocks leave no trace
            push_valid = req_valid && (req_data.byte_count != '0);
         end
         CMD_FIN: begin
            push_valid    = req_valid;
            push_op.data  = '0;
            push_op.count = '0;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/pvh_fifo.sv */
`default_nettype none

module pvh_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire pvh_pkg::op_type      push_op,
   input  wire logic                 pop,
   output pvh_pkg::q_head_type       head,
   output pvh_pkg::q_status_type     status
);
   import pvh_pkg::*;

   op_type          mem_ff [0:Q_DEPTH-1];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] count_ff, count_in;
   logic            wr_en;

   always_comb begin
      status.full  = (count_ff == Q_CW'(Q_DEPTH));
      status.empty = (count_ff == '0);
      wr_en        = push_valid && !status.full;
      head.valid   = !status.empty;
      head.op      = mem_ff[rd_ptr_ff];
      wr_ptr_in    = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff + Q_CW'(wr_en) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= push_op;
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CW'(Q_DEPTH))
      else $error("queue holds more beats than its depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/pvh_back.sv */
`default_nettype none

module pvh_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [pvh_pkg::HALF_W-1:0] csr_wdata,
   input  wire pvh_pkg::q_head_type        head,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output pvh_pkg::rsp_type                rsp_data
);
   import pvh_pkg::*;

   logic [HALF_W-1:0]  key_low_ff, key_low_in;
   logic [HALF_W-1:0]  key_high_ff, key_high_in;
   logic               key_ready_ff, key_ready_in;
   logic [BLK_W-1:0]   skey_ff, skey_in;
   logic [BLK_W-1:0]   acc_ff, acc_in;
   logic [TOTAL_W-1:0] aad_total_ff, aad_total_in;
   logic [TOTAL_W-1:0] msg_total_ff, msg_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]   tag_ff, tag_in;

   logic [BLK_W-1:0]   blk;
   logic [BLK_W-1:0]   mul_a;
   logic [BLK_W-1:0]   mul_b;
   logic [BLK_W-1:0]   prod;
   logic               is_fin;
   logic               out_free;
   logic [TOTAL_W:0]   aad_sum;
   logic [TOTAL_W:0]   msg_sum;

   always_comb begin
      is_fin   = (head.op.cmd == CMD_FIN);
      out_free = !rsp_valid_ff || !rsp_stall;
      pop      = head.valid && key_ready_ff && (!is_fin || out_free);

      // length block: bit counts, AAD in the low half
      blk = is_fin ? {29'd0, msg_total_ff, 3'd0, 29'd0, aad_total_ff, 3'd0} : head.op.data;

      // multiplier is borrowed to scale a fresh key while the scaled key is not ready
      if (key_ready_ff) begin
         mul_a = acc_ff ^ blk;
         mul_b = skey_ff;
      end else begin
         mul_a = {key_high_ff, key_low_ff};
         mul_b = X_INV;
      end
      prod = gf_mul(mul_a, mul_b);

      aad_sum = {1'b0, aad_total_ff} + (TOTAL_W+1)'(head.op.count);
      msg_sum = {1'b0, msg_total_ff} + (TOTAL_W+1)'(head.op.count);

      key_low_in   = key_low_ff;
      key_high_in  = key_high_ff;
      key_ready_in = key_ready_ff;
      skey_in      = skey_ff;
      acc_in       = acc_ff;
      aad_total_in = aad_total_ff;
      msg_total_in = msg_total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tag_in       = tag_ff;

      if (csr_we) begin
         key_ready_in = 1'b0;
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_in  = csr_wdata;
            CSR_KEY_HIGH: key_high_in = csr_wdata;
         endcase
      end else if (!key_ready_ff) begin
         skey_in      = prod;
         key_ready_in = 1'b1;
      end

      if (pop) begin
         unique case (head.op.cmd)
            CMD_AAD: begin
               acc_in       = prod;
               aad_total_in = aad_sum[TOTAL_W] ? '1 : aad_sum[TOTAL_W-1:0];
            end
            CMD_MSG: begin
               acc_in       = prod;
               msg_total_in = msg_sum[TOTAL_W] ? '1 : msg_sum[TOTAL_W-1:0];
            end
            CMD_FIN: begin
               acc_in       = '0;
               aad_total_in = '0;
               msg_total_in = '0;
               tag_in       = prod;
               rsp_valid_in = 1'b1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         key_ready_ff <= 1'b0;
         skey_ff      <= '0;
         acc_ff       <= '0;
         aad_total_ff <= '0;
         msg_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
         key_ready_ff <= key_ready_in;
         skey_ff      <= skey_in;
         acc_ff       <= acc_in;
         aad_total_ff <= aad_total_in;
         msg_total_ff <= msg_total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.tag_low  = tag_ff[HALF_W-1:0];
   assign rsp_data.tag_high = tag_ff[BLK_W-1:HALF_W];

   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      pop && is_fin |=> rsp_valid_ff && acc_ff == '0 && aad_total_ff == '0
                        && msg_total_ff == '0)
      else $error("finish did not post tag and clear state");

   a_key_write_unready: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !key_ready_ff)
      else $error("key write left scaled key marked ready");

   a_key_scales: assert property (@(posedge clock) disable iff (reset)
      !key_ready_ff && !csr_we |=> key_ready_ff)
      else $error("scaled key not formed in one cycle");

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
   import pvh_pkg::*;

   localparam logic [1:0]   CMD_NONE    = 2'd3;
   localparam logic [63:0]  ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
   // x^128 folded back: x^127 + x^126 + x^121 + 1
   localparam logic [127:0] FOLD_POLY   = 128'hC200_0000_0000_0000_0000_0000_0000_0001;
   localparam logic [127:0] INV_X128    = 128'h9204_0000_0000_0000_0000_0000_0000_0001;
   localparam int           SETTLE_CYC  = 12;
   localparam int           HOLD_CYC    = 400;

   class tag_board;
      logic [127:0] hash_key;
      logic [127:0] scaled;
      bit           scaled_ok;
      logic [127:0] acc;
      logic [31:0]  aad_bytes;
      logic [31:0]  msg_bytes;
      rsp_type      tags[$];
      int           errors;

      function new();
         hash_key  = '0;
         scaled    = '0;
         scaled_ok = 0;
         acc       = '0;
         aad_bytes = '0;
         msg_bytes = '0;
         errors    = 0;
      endfunction

      // shift-and-add multiply, little-endian bit order (bit i is x^i)
      function logic [127:0] field_mul(logic [127:0] a, logic [127:0] b);
         logic [127:0] z;
         logic [127:0] v;
         logic         carry;
         z = '0;
         v = b;
         for (int i = 0; i < 128; i++) begin
            if (a[i]) z ^= v;
            carry = v[127];
            v = v << 1;
            if (carry) v ^= FOLD_POLY;
         end
         return z;
      endfunction

      function logic [31:0] add_sat(logic [31:0] total, logic [4:0] n);
         logic [32:0] sum;
         sum = {1'b0, total} + 33'(n);
         return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      endfunction

      function void load_key(logic idx, logic [63:0] val);
         if (idx == CSR_KEY_LOW) hash_key[63:0] = val;
         else hash_key[127:64] = val;
         scaled_ok = 0;
      endfunction

      function void fold_in(logic [127:0] blk);
         if (!scaled_ok) begin
            scaled    = field_mul(hash_key, INV_X128);
            scaled_ok = 1;
         end
         acc = field_mul(acc ^ blk, scaled);
      endfunction

      function void note_request(req_type r);
         logic [4:0]   n;
         logic [127:0] mask;
         rsp_type      t;
         n = (r.byte_count > 5'd16) ? 5'd16 : r.byte_count;
         if (r.cmd == CMD_AAD || r.cmd == CMD_MSG) begin
            if (n == 0) return;
            mask = (n == 5'd16) ? '1 : ((128'd1 << (8 * n)) - 128'd1);
            fold_in({r.block_high, r.block_low} & mask);
            if (r.cmd == CMD_AAD) aad_bytes = add_sat(aad_bytes, n);
            else msg_bytes = add_sat(msg_bytes, n);
         end else if (r.cmd == CMD_FIN) begin
            fold_in({29'd0, msg_bytes, 3'd0, 29'd0, aad_bytes, 3'd0});
            t.tag_low  = acc[63:0];
            t.tag_high = acc[127:64];
            tags.push_back(t);
            acc       = '0;
            aad_bytes = '0;
            msg_bytes = '0;
         end
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
      endfunction

      function void check_tag(rsp_type got);
         rsp_type want;
         if (tags.size() == 0) begin
            flag($sformatf("tag with none pending: high %h low %h",
                           got.tag_high, got.tag_low));
            return;
         end
         want = tags.pop_front();
         if (got.tag_low !== want.tag_low || got.tag_high !== want.tag_high)
            flag($sformatf("tag_low exp %h got %h, tag_high exp %h got %h",
                           want.tag_low, got.tag_low, want.tag_high, got.tag_high));
      endfunction

      function int pending();
         return tags.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [63:0] csr_wdata;

   tag_board board;
   int       burst_left;
   bit       quiet;
   int       hold_req;

   polyval_universal_hash dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type make_beat(logic [1:0] c, logic [63:0] lo, logic [63:0] hi,
                                         logic [4:0] n);
      req_type r;
      r.cmd        = c;
      r.block_low  = lo;
      r.block_high = hi;
      r.byte_count = n;
      return r;
   endfunction

   // ignored beats (unused cmd, empty absorb) don't count toward the stimulus budget
   function automatic bit is_live(req_type r);
      return r.cmd == CMD_FIN || (r.cmd != CMD_NONE && r.byte_count != 0);
   endfunction

   task automatic offer(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = quiet ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(r);
   endtask

   // drop valid and wait for every tag, then let queued absorbs finish
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock) csr_we <= 1'b0;
      board.load_key(idx, val);
   endtask

   task automatic random_traffic(input int budget, input bit squeeze);
      int      count;
      int      n_aad;
      int      n_msg;
      bit      paused;
      req_type r;
      count  = 0;
      paused = 0;
      while (count < budget) begin
         if (!paused && count >= budget / 2) begin
            settle();
            paused = 1;
         end
         if (squeeze && count >= 20) begin
            hold_req++;
            squeeze = 0;
         end
         if ($urandom_range(0, 9) == 0) begin
            r = make_beat(2'($urandom_range(0, 3)), rand64(), rand64(),
                          5'($urandom_range(0, 31)));
            offer(r);
            if (is_live(r)) count++;
         end else begin
            n_aad = $urandom_range(0, 3);
            n_msg = $urandom_range(0, 6);
            for (int i = 0; i < n_aad; i++) begin
               offer(make_beat(CMD_AAD, rand64(), rand64(),
                               5'((i == n_aad - 1) ? $urandom_range(1, 16) : 16)));
               count++;
            end
            for (int i = 0; i < n_msg; i++) begin
               offer(make_beat(CMD_MSG, rand64(), rand64(),
                               5'((i == n_msg - 1) ? $urandom_range(1, 16) : 16)));
               count++;
            end
            // now and then the finish is dropped and the next message runs on
            if ($urandom_range(0, 15) != 0) begin
               offer(make_beat(CMD_FIN, rand64(), rand64(), 5'($urandom_range(0, 31))));
               count++;
            end
         end
      end
   endtask

   // result side: stall pattern changes per segment, plus a long hold on request
   initial begin
      int seg;
      int mode;
      int hold;
      int hold_seen;
      rsp_stall = 1'b0;
      seg       = 0;
      mode      = 0;
      hold      = 0;
      hold_seen = 0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold      = HOLD_CYC;
            hold_seen = hold_req;
         end
         if (seg == 0) begin
            seg  = $urandom_range(10, 80);
            mode = $urandom_range(0, 2);
         end
         seg--;
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) board.check_tag(rsp_data);
   end

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [63:0] key_lo;
      logic [63:0] key_hi;
      board      = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_KEY_LOW;
      csr_wdata  = '0;
      burst_left = 0;
      quiet      = 0;
      hold_req   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: byte masks, empty and oversized counts, unused cmd, back-to-back finishes
      write_csr(CSR_KEY_LOW, ALL_ONES);
      write_csr(CSR_KEY_HIGH, rand64());
      offer(make_beat(CMD_AAD, ALL_ONES, ALL_ONES, 16));
      offer(make_beat(CMD_AAD, ALL_ONES, ALL_ONES, 1));
      offer(make_beat(CMD_AAD, ALL_ONES, ALL_ONES, 0));
      offer(make_beat(CMD_AAD, rand64(), rand64(), 31));
      offer(make_beat(CMD_NONE, rand64(), rand64(), 16));
      offer(make_beat(CMD_MSG, ALL_ONES, ALL_ONES, 8));
      offer(make_beat(CMD_MSG, ALL_ONES, ALL_ONES, 9));
      offer(make_beat(CMD_MSG, ALL_ONES, ALL_ONES, 15));
      offer(make_beat(CMD_MSG, '0, '0, 17));
      offer(make_beat(CMD_MSG, ALL_ONES, ALL_ONES, 0));
      offer(make_beat(CMD_FIN, ALL_ONES, ALL_ONES, 0));
      offer(make_beat(CMD_FIN, '0, '0, 31));
      offer(make_beat(CMD_MSG, '0, '0, 16));
      offer(make_beat(CMD_FIN, rand64(), rand64(), 16));
      offer(make_beat(CMD_AAD, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 7));
      offer(make_beat(CMD_MSG, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 16));
      // key swap with a message open: accumulator and totals carry over
      settle();
      write_csr(CSR_KEY_HIGH, rand64());
      offer(make_beat(CMD_MSG, rand64(), rand64(), 16));
      offer(make_beat(CMD_FIN, rand64(), rand64(), 1));

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         case (ph)
            0: begin key_lo = '0;       key_hi = '0;       end
            1: begin key_lo = ALL_ONES; key_hi = ALL_ONES; end
            2: begin key_lo = 64'd1;    key_hi = '0;       end
            3: begin key_lo = '0;       key_hi = ALL_ONES; end
            default: begin key_lo = rand64(); key_hi = rand64(); end
         endcase
         write_csr(CSR_KEY_LOW, key_lo);
         write_csr(CSR_KEY_HIGH, key_hi);
         quiet = (ph == 2);
         random_traffic(190, ph == 3 || ph == 6);
      end

      settle();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
